/* rtl/mi_pkg.sv */
// ----------------------------------------------------------------------------
// mi_pkg: shared types and constants for the modular inverse core
// Command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package mi_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  typedef logic [WIDTH-1:0] word_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_LOAD = 3'd1,  // capture operands, start reducing value mod modulus
    OP_DIV  = 3'd2,  // one restoring division step
    OP_MUL  = 3'd3,  // one shift-and-add modular multiply step
    OP_INIT = 3'd4,  // set up Euclid registers after reduction
    OP_DSET = 3'd5,  // set up a Euclid division
    OP_MSET = 3'd6,  // set up the multiply from the quotient
    OP_UPD  = 3'd7   // rotate remainders and coefficients
  } op_t;

  typedef struct packed {
    op_t op;
  } mi_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic trivial;    // modulus <= 1
    logic rem_zero;   // reduced value or next remainder is zero
  } mi_sts_t;

endpackage

/* rtl/mi_datapath.sv */
// ----------------------------------------------------------------------------
// mi_datapath: registers and arithmetic for the modular inverse
// Bit-serial divider and bit-serial modular multiplier, shared over all
// Euclid iterations.
// ----------------------------------------------------------------------------
module mi_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  mi_pkg::mi_cmd_t   cmd,
  input  mi_pkg::word_t     value,
  input  mi_pkg::word_t     modulus,
  output mi_pkg::mi_sts_t   sts,
  output mi_pkg::word_t     result
);
  import mi_pkg::*;

  word_t m_r, m_nxt;
  word_t rem_r, rem_nxt, nrem_r, nrem_nxt;
  word_t coef_r, coef_nxt, ncoef_r, ncoef_nxt;
  // divider: dividend shifts into partial remainder, quotient collects
  word_t dvd_r, dvd_nxt, dvs_r, dvs_nxt, prem_r, prem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  // multiplier
  word_t mx_r, mx_nxt, my_r, my_nxt, acc_r, acc_nxt;

  logic [WIDTH:0] trial;
  word_t qn, nc;

  function automatic word_t add_mod(word_t x, word_t y, word_t m);
    word_t room;
    room = m - y;
    if (x >= room) return x - room;
    return x + y;
  endfunction

  always_comb begin
    trial = {prem_r, dvd_r[WIDTH-1]} - {1'b0, dvs_r};
    qn = acc_r;
    nc = (coef_r >= qn) ? coef_r - qn : m_r - (qn - coef_r);
  end

  always_comb begin
    m_nxt = m_r; rem_nxt = rem_r; nrem_nxt = nrem_r;
    coef_nxt = coef_r; ncoef_nxt = ncoef_r;
    dvd_nxt = dvd_r; dvs_nxt = dvs_r; prem_nxt = prem_r; cnt_nxt = cnt_r;
    mx_nxt = mx_r; my_nxt = my_r; acc_nxt = acc_r;
    case (cmd.op)
      OP_LOAD: begin
        m_nxt = modulus; dvd_nxt = value; dvs_nxt = modulus;
        prem_nxt = '0; cnt_nxt = CNT_W'(WIDTH);
      end
      OP_DIV: begin
        if (!trial[WIDTH]) begin
          prem_nxt = trial[WIDTH-1:0];
          dvd_nxt = {dvd_r[WIDTH-2:0], 1'b1};
        end else begin
          prem_nxt = {prem_r[WIDTH-2:0], dvd_r[WIDTH-1]};
          dvd_nxt = {dvd_r[WIDTH-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
      end
      OP_INIT: begin
        rem_nxt = m_r; nrem_nxt = prem_r; coef_nxt = '0; ncoef_nxt = word_t'(1);
      end
      OP_DSET: begin
        dvd_nxt = rem_r; dvs_nxt = nrem_r; prem_nxt = '0; cnt_nxt = CNT_W'(WIDTH);
      end
      OP_MSET: begin
        // quotient <= modulus holds here (rem <= m, nrem >= 1 and q < m
        // unless nrem = 1 with rem = m; that only happens on the first step
        // when a = 1, where q = m reduces to 0)
        mx_nxt = (dvd_r >= m_r) ? dvd_r - m_r : dvd_r;
        my_nxt = ncoef_r; acc_nxt = '0;
      end
      OP_MUL: begin
        if (my_r[0]) acc_nxt = add_mod(acc_r, mx_r, m_r);
        mx_nxt = add_mod(mx_r, mx_r, m_r);
        my_nxt = my_r >> 1;
      end
      OP_UPD: begin
        rem_nxt = nrem_r; nrem_nxt = prem_r;
        coef_nxt = ncoef_r; ncoef_nxt = nc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt; rem_r <= rem_nxt; nrem_r <= nrem_nxt;
    coef_r <= coef_nxt; ncoef_r <= ncoef_nxt;
    dvd_r <= dvd_nxt; dvs_r <= dvs_nxt; prem_r <= prem_nxt;
    mx_r <= mx_nxt; my_r <= my_nxt; acc_r <= acc_nxt;
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  always_comb begin
    sts.div_done = (cnt_r == '0);
    sts.mul_done = (my_r == '0);
    sts.trivial  = (m_r <= word_t'(1));
    sts.rem_zero = (prem_r == '0);
    result = (rem_r == word_t'(1)) ? coef_r : '0;
  end

endmodule

/* rtl/mi_ctrl.sv */
// ----------------------------------------------------------------------------
// mi_ctrl: sequencer for the modular inverse
// Steps the datapath through reduction, Euclid divisions and multiplies.
// ----------------------------------------------------------------------------
module mi_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  mi_pkg::mi_sts_t sts,
  output mi_pkg::mi_cmd_t cmd,
  output logic            zero_res
);
  import mi_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RED  = 9'b000000010,
    S_CHK  = 9'b000000100,
    S_DSET = 9'b000001000,
    S_DIV  = 9'b000010000,
    S_MSET = 9'b000100000,
    S_MUL  = 9'b001000000,
    S_UPD  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic zero_r, zero_nxt;

  always_comb begin
    state_nxt = state_r;
    zero_nxt = zero_r;
    cmd.op = OP_NONE;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD; state_nxt = S_RED;
        end
      end
      S_RED: begin
        if (sts.div_done) state_nxt = S_CHK;
        else cmd.op = OP_DIV;
      end
      S_CHK: begin
        if (sts.trivial || sts.rem_zero) begin
          zero_nxt = 1'b1; state_nxt = S_OUT;
        end else begin
          zero_nxt = 1'b0; cmd.op = OP_INIT; state_nxt = S_DSET;
        end
      end
      S_DSET: begin
        cmd.op = OP_DSET; state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_MSET;
        else cmd.op = OP_DIV;
      end
      S_MSET: begin
        cmd.op = OP_MSET; state_nxt = S_MUL;
      end
      S_MUL: begin
        if (sts.mul_done) state_nxt = S_UPD;
        else cmd.op = OP_MUL;
      end
      S_UPD: begin
        cmd.op = OP_UPD;
        state_nxt = sts.rem_zero ? S_OUT : S_DSET;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      zero_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      zero_r <= zero_nxt;
    end
  end

  assign zero_res = zero_r;

endmodule

/* rtl/modular_inverse_u32_core.sv */
// ----------------------------------------------------------------------------
// modular_inverse_u32_core: 32-bit modular inverse, extended Euclid
// After the accepting edge the value is first reduced by serial division;
// unless the modulus is at most 1 or the reduced value is zero, each Euclid
// iteration then runs a serial division, a serial modular multiply and one
// update. One transaction at a time; the next is taken once the result leaves.
// Synchronous active-low reset returns the sequencer to idle.
// ----------------------------------------------------------------------------
module modular_inverse_u32_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mi_pkg::word_t       in_value,
  input  mi_pkg::word_t       in_modulus,
  output logic                out_valid,
  input  logic                out_ready,
  output mi_pkg::word_t       out_inverse
);
  import mi_pkg::*;

  mi_cmd_t cmd;
  mi_sts_t sts;
  word_t   res;
  logic    zero_res;

  mi_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts, .cmd, .zero_res
  );

  mi_datapath u_dp (
    .clk, .rst_n, .cmd, .value(in_value), .modulus(in_modulus),
    .sts, .result(res)
  );

  assign out_inverse = zero_res ? '0 : res;

endmodule

/* sim/modular_inverse_u32_core_test.sv */
// ----------------------------------------------------------------------------
// modular_inverse_u32_core_test: self-checking bench for the modular inverse
// Drives value/modulus pairs through the valid/ready handshake, predicts each
// inverse with an independent extended Euclid and compares results in order.
// ----------------------------------------------------------------------------
module modular_inverse_u32_core_test;
  import mi_pkg::*;

  class inverse_scoreboard;
    word_t inv_q[$];
    int    mismatches;

    // extended Euclid with the coefficient held as a residue mod m
    function word_t predict_inverse(word_t value, word_t modulus);
      logic [63:0] m, r0, r1, c0, c1, q, qn, nc, t;
      if (modulus <= 1) return '0;
      m  = modulus;
      r0 = m;
      r1 = value % m;
      if (r1 == 0) return '0;
      c0 = 0;
      c1 = 1;
      while (r1 != 0) begin
        q  = r0 / r1;
        t  = r0 - q * r1;
        qn = ((q % m) * c1) % m;
        r0 = r1;
        r1 = t;
        nc = (c0 >= qn) ? c0 - qn : m - (qn - c0);
        c0 = c1;
        c1 = nc;
      end
      if (r0 != 1) return '0;
      return word_t'(c0 % m);
    endfunction

    function void note_operands(word_t value, word_t modulus);
      inv_q.push_back(predict_inverse(value, modulus));
    endfunction

    function void check_inverse(word_t got);
      word_t want;
      if (inv_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: inverse %h", got);
        return;
      end
      want = inv_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("inverse mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic  clk, rst_n;
  logic  in_valid, in_ready, out_valid, out_ready;
  word_t in_value, in_modulus, out_inverse;
  int    send_idle_pct, recv_idle_pct;
  int    quiet_cycles;
  inverse_scoreboard sb;

  modular_inverse_u32_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_value(in_value), .in_modulus(in_modulus),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_inverse(out_inverse)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // score on rising edges; the watchdog counts edges with no transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_inverse(out_inverse);
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 40000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_pair(word_t value, word_t modulus);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid   <= 1'b1;
    in_value   <= value;
    in_modulus <= modulus;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_operands(value, modulus);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_pairs(int n);
    word_t m;
    for (int i = 0; i < n; i++) begin
      m = rand_word();
      case ($urandom_range(9))
        0: send_pair(m * $urandom_range(5), m);   // multiple of the modulus
        1: send_pair(rand_word() & ~32'h1, m & ~32'h1);  // shared factor two
        default: send_pair(rand_word(), m);
      endcase
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    in_modulus = '0;
    send_idle_pct = 15;
    recv_idle_pct = 69;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_pair(32'd5, 32'd0);
    send_pair(32'd7, 32'd1);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'd0, 32'd13);
    send_pair(32'd26, 32'd13);
    send_pair(32'd6, 32'd9);
    send_pair(32'd3, 32'd7);
    send_pair(32'd1, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFB);
    send_pair(32'hFFFF_FFFF, 32'd2);
    send_pair(32'd0, 32'hFFFF_FFFF);
    send_pair(32'hB504_F333, 32'h9E37_79B9);
    send_pair(32'd1, 32'd2);
    send_pair(32'h8000_0000, 32'h8000_0001);
    send_pair(32'd4, 32'h8000_0000);
    send_pair(32'hFFFF_FFFF, 32'h8000_0000);
    random_pairs(90);

    send_idle_pct = 69;
    recv_idle_pct = 15;
    random_pairs(100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_pairs(100);

    while (sb.inv_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.inv_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
